FILE: rtl/core/sit_pkg.sv
// Shared widths, reset values, codes and record types of the segment intersection test.
package sit_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int DIST_FRAC  = 24;
  localparam int EPS_W      = 24;
  localparam int OUT_W      = 32;

  // Coordinate differences, cross products and their magnitudes.
  localparam int DW   = COORD_BITS + 1;
  localparam int PW   = 2 * DW + 1;
  localparam int MW   = 2 * DW;
  localparam int LW   = 2 * DW;
  localparam int E2W  = 2 * EPS_W;
  localparam int EH   = EPS_W;
  localparam int LLW  = 2 * LW;
  localparam int CK   = (LLW + 2) / 3;
  localparam int CMPW = 2 * MW + 2 * DIST_FRAC;

  // Quotient and dividend of the crossing point.
  localparam int QW = COORD_BITS + FRAC_BITS;
  localparam int NW = COORD_BITS + MW;
  localparam int VW = (QW + 2 > OUT_W) ? QW + 2 : OUT_W;

  localparam int INTER_EPS_RST    = 2;
  localparam int RIGHT_EPS_RST    = 200;
  localparam int PARALLEL_EPS_RST = 2;

  localparam logic [E2W-1:0] INTER_SQ_RST    = E2W'(INTER_EPS_RST * INTER_EPS_RST);
  localparam logic [E2W-1:0] RIGHT_SQ_RST    = E2W'(RIGHT_EPS_RST * RIGHT_EPS_RST);
  localparam logic [E2W-1:0] PARALLEL_SQ_RST = E2W'(PARALLEL_EPS_RST * PARALLEL_EPS_RST);

  typedef enum logic [1:0] {
    CFG_INTER_EPS    = 2'd0,
    CFG_RIGHT_EPS    = 2'd1,
    CFG_PARALLEL_EPS = 2'd2
  } sit_cfg_e;

  typedef enum logic [1:0] {
    CLS_LEFT  = 2'd0,
    CLS_RIGHT = 2'd1,
    CLS_ON    = 2'd2
  } sit_cls_e;

  typedef struct packed {
    logic                         strict_hit;
    logic                         found;
    logic                         parallel;
    logic                         neg_x;
    logic                         neg_y;
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
  } sit_side_t;

  typedef struct packed {
    sit_side_t       side;
    logic [MW-1:0]   den;
    logic [NW-1:0]   nx;
    logic [NW-1:0]   ny;
  } sit_div_in_t;

  typedef struct packed {
    sit_side_t       side;
    logic [MW-1:0]   den;
    logic [QW-1:0]   qx;
    logic [MW-1:0]   rx;
    logic [QW-1:0]   qy;
    logic [MW-1:0]   ry;
  } sit_div_out_t;

  typedef struct packed {
    logic                    strict_hit;
    logic                    found;
    logic                    parallel;
    logic signed [OUT_W-1:0] cx;
    logic signed [OUT_W-1:0] cy;
  } sit_res_t;

endpackage

FILE: rtl/core/segment_intersection_test_core.sv
// Top level of the segment intersection test: eight arithmetic stages, divider, output buffer.
//
// The core takes one segment pair per cycle while the output buffer has room and returns
// one result per pair, in order. Eight stages form the differences, cross products, squared
// lengths and the exact wide comparisons against the squared thresholds; a 32-stage divider
// then produces the crossing quotient one bit per stage, and its depth sets the latency. A
// two-entry output buffer lets the pipeline keep moving while one result waits; the whole
// pipeline holds only when both entries are occupied. Threshold writes take effect at the
// next cycle and must be done while no request is in flight.
module segment_intersection_test_core import sit_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_idx_i,
  input  logic [EPS_W-1:0]             cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] a_start_x_i,
  input  logic signed [COORD_BITS-1:0] a_start_y_i,
  input  logic signed [COORD_BITS-1:0] a_end_x_i,
  input  logic signed [COORD_BITS-1:0] a_end_y_i,
  input  logic signed [COORD_BITS-1:0] b_start_x_i,
  input  logic signed [COORD_BITS-1:0] b_start_y_i,
  input  logic signed [COORD_BITS-1:0] b_end_x_i,
  input  logic signed [COORD_BITS-1:0] b_end_y_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         strict_hit_o,
  output logic                         point_found_o,
  output logic                         lines_parallel_o,
  output logic signed [OUT_W-1:0]      cross_x_o,
  output logic signed [OUT_W-1:0]      cross_y_o
);

  logic       adv;
  logic [1:0] cnt_q, cnt_d;

  assign adv        = (cnt_q != 2'd2);
  assign in_ready_o = adv;

  // Threshold squares are formed when written.
  logic [E2W-1:0] ri2_q, rr2_q, rp2_q;
  logic           inz_q;
  logic [E2W-1:0] wsq;

  assign wsq = cfg_wdata_i * cfg_wdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ri2_q <= INTER_SQ_RST;
      rr2_q <= RIGHT_SQ_RST;
      rp2_q <= PARALLEL_SQ_RST;
      inz_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (sit_cfg_e'(cfg_idx_i))
        CFG_INTER_EPS: begin
          ri2_q <= wsq;
          inz_q <= |cfg_wdata_i;
        end
        CFG_RIGHT_EPS:    rr2_q <= wsq;
        CFG_PARALLEL_EPS: rp2_q <= wsq;
        default: ;
      endcase
    end
  end

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
      v5_q <= 1'b0; v6_q <= 1'b0; v7_q <= 1'b0; v8_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q;
      v5_q <= v4_q; v6_q <= v5_q; v7_q <= v6_q; v8_q <= v7_q;
    end
  end

  // Stage 1: differences.
  logic signed [DW-1:0] ux_d, uy_d, vx_d, vy_d, wx_d, wy_d, ex_d, ey_d;
  logic signed [DW-1:0] s1_ux_q, s1_uy_q, s1_vx_q, s1_vy_q, s1_wx_q, s1_wy_q, s1_ex_q, s1_ey_q;
  logic signed [COORD_BITS-1:0] s1_ax_q, s1_ay_q;

  assign ux_d = DW'(a_end_x_i) - DW'(a_start_x_i);
  assign uy_d = DW'(a_end_y_i) - DW'(a_start_y_i);
  assign vx_d = DW'(b_end_x_i) - DW'(b_start_x_i);
  assign vy_d = DW'(b_end_y_i) - DW'(b_start_y_i);
  assign wx_d = DW'(b_start_x_i) - DW'(a_start_x_i);
  assign wy_d = DW'(b_start_y_i) - DW'(a_start_y_i);
  assign ex_d = DW'(b_end_x_i) - DW'(a_start_x_i);
  assign ey_d = DW'(b_end_y_i) - DW'(a_start_y_i);

  // Stage 2: products.
  logic signed [2*DW-1:0] p_uxwy_d, p_uywx_d, p_uxey_d, p_uyex_d;
  logic signed [2*DW-1:0] p_uxvy_d, p_uyvx_d, p_wxvy_d, p_wyvx_d;
  logic signed [2*DW-1:0] q_ux_d, q_uy_d, q_vx_d, q_vy_d;
  logic signed [DW-1:0]   abx_d, aby_d;
  logic signed [2*DW-1:0] s2_uxwy_q, s2_uywx_q, s2_uxey_q, s2_uyex_q;
  logic signed [2*DW-1:0] s2_uxvy_q, s2_uyvx_q, s2_wxvy_q, s2_wyvx_q;
  logic signed [2*DW-1:0] s2_qux_q, s2_quy_q, s2_qvx_q, s2_qvy_q;
  logic [COORD_BITS-1:0]  s2_abx_q, s2_aby_q;
  logic                   s2_negx_q, s2_negy_q;
  logic signed [COORD_BITS-1:0] s2_ax_q, s2_ay_q;

  assign p_uxwy_d = s1_ux_q * s1_wy_q;
  assign p_uywx_d = s1_uy_q * s1_wx_q;
  assign p_uxey_d = s1_ux_q * s1_ey_q;
  assign p_uyex_d = s1_uy_q * s1_ex_q;
  assign p_uxvy_d = s1_ux_q * s1_vy_q;
  assign p_uyvx_d = s1_uy_q * s1_vx_q;
  assign p_wxvy_d = s1_wx_q * s1_vy_q;
  assign p_wyvx_d = s1_wy_q * s1_vx_q;
  assign q_ux_d   = s1_ux_q * s1_ux_q;
  assign q_uy_d   = s1_uy_q * s1_uy_q;
  assign q_vx_d   = s1_vx_q * s1_vx_q;
  assign q_vy_d   = s1_vy_q * s1_vy_q;
  assign abx_d    = s1_ux_q[DW-1] ? -s1_ux_q : s1_ux_q;
  assign aby_d    = s1_uy_q[DW-1] ? -s1_uy_q : s1_uy_q;

  // Stage 3: cross products and squared lengths.
  logic signed [PW-1:0] cr0_d, cr1_d, den_d, tn_d;
  logic [LW-1:0]        lu_d, lv_d;
  logic signed [PW-1:0] s3_cr0_q, s3_cr1_q, s3_den_q, s3_tn_q;
  logic [LW-1:0]        s3_lu_q, s3_lv_q;
  logic [COORD_BITS-1:0] s3_abx_q, s3_aby_q;
  logic                 s3_negx_q, s3_negy_q;
  logic signed [COORD_BITS-1:0] s3_ax_q, s3_ay_q;

  assign cr0_d = PW'(s2_uxwy_q) - PW'(s2_uywx_q);
  assign cr1_d = PW'(s2_uxey_q) - PW'(s2_uyex_q);
  assign den_d = PW'(s2_uxvy_q) - PW'(s2_uyvx_q);
  assign tn_d  = PW'(s2_wxvy_q) - PW'(s2_wyvx_q);
  assign lu_d  = $unsigned(s2_qux_q) + $unsigned(s2_quy_q);
  assign lv_d  = $unsigned(s2_qvx_q) + $unsigned(s2_qvy_q);

  // Stage 4: sign normalization. The B parameter numerator is the negated first cross.
  logic signed [PW-1:0] dn_d, tnn_d, snn_d, m0_full, m1_full;
  logic signed [PW-1:0] s4_dn_q, s4_tnn_q, s4_snn_q;
  logic [MW-1:0]        s4_m0_q, s4_m1_q;
  logic                 s4_pos0_q, s4_pos1_q, s4_lu0_q, s4_lv0_q;
  logic [LW-1:0]        s4_lu_q, s4_lv_q;
  logic [COORD_BITS-1:0] s4_abx_q, s4_aby_q;
  logic                 s4_negx_q, s4_negy_q;
  logic signed [COORD_BITS-1:0] s4_ax_q, s4_ay_q;

  assign dn_d    = s3_den_q[PW-1] ? -s3_den_q : s3_den_q;
  assign tnn_d   = s3_den_q[PW-1] ? -s3_tn_q : s3_tn_q;
  assign snn_d   = s3_den_q[PW-1] ? s3_cr0_q : -s3_cr0_q;
  assign m0_full = s3_cr0_q[PW-1] ? -s3_cr0_q : s3_cr0_q;
  assign m1_full = s3_cr1_q[PW-1] ? -s3_cr1_q : s3_cr1_q;

  // Stage 5: range flags and products for the wide comparisons.
  logic                  ok_d;
  logic [2*MW-1:0]       c0sq_d, c1sq_d, dsq_d;
  logic [EH+LW-1:0]      rrh_d, rrl_d, rih_d, ril_d;
  logic [LLW-1:0]        lulv_d;
  logic [NW-1:0]         nx_d, ny_d;
  logic                  s5_ok_q, s5_pos0_q, s5_pos1_q, s5_lu0_q, s5_lv0_q;
  logic [2*MW-1:0]       s5_c0sq_q, s5_c1sq_q, s5_dsq_q;
  logic [EH+LW-1:0]      s5_rrh_q, s5_rrl_q, s5_rih_q, s5_ril_q;
  logic [LLW-1:0]        s5_lulv_q;
  logic [NW-1:0]         s5_nx_q, s5_ny_q;
  logic [MW-1:0]         s5_dn_q;
  logic                  s5_negx_q, s5_negy_q;
  logic signed [COORD_BITS-1:0] s5_ax_q, s5_ay_q;

  assign ok_d   = (s4_tnn_q > 0) && (s4_tnn_q < s4_dn_q) && (s4_snn_q > 0) &&
                  (s4_snn_q < s4_dn_q);
  assign c0sq_d = s4_m0_q * s4_m0_q;
  assign c1sq_d = s4_m1_q * s4_m1_q;
  assign dsq_d  = s4_dn_q[MW-1:0] * s4_dn_q[MW-1:0];
  assign rrh_d  = rr2_q[E2W-1:EH] * s4_lu_q;
  assign rrl_d  = rr2_q[EH-1:0] * s4_lu_q;
  assign rih_d  = ri2_q[E2W-1:EH] * s4_lu_q;
  assign ril_d  = ri2_q[EH-1:0] * s4_lu_q;
  assign lulv_d = s4_lu_q * s4_lv_q;
  assign nx_d   = s4_abx_q * s4_tnn_q[MW-1:0];
  assign ny_d   = s4_aby_q * s4_tnn_q[MW-1:0];

  // Stage 6: point classes against A, partial products of the parallel bound.
  logic [CMPW-1:0] rr_sum, ri_sum, lhs0, lhs1;
  sit_cls_e        cls0, cls1;
  logic            straddle_d;
  logic [3*CK-1:0] lulv_ext;
  logic [CK-1:0]   chunk [3];
  logic [EH-1:0]   rph [2];
  logic [EH+CK-1:0] pp_d [2][3];
  logic [EH+CK-1:0] s6_pp_q [2][3];
  logic            s6_straddle_q, s6_ok_q, s6_lu0_q, s6_lv0_q;
  logic [2*MW-1:0] s6_dsq_q;
  logic [NW-1:0]   s6_nx_q, s6_ny_q;
  logic [MW-1:0]   s6_dn_q;
  logic            s6_negx_q, s6_negy_q;
  logic signed [COORD_BITS-1:0] s6_ax_q, s6_ay_q;

  assign rr_sum = (CMPW'(s5_rrh_q) << EH) + CMPW'(s5_rrl_q);
  assign ri_sum = (CMPW'(s5_rih_q) << EH) + CMPW'(s5_ril_q);
  assign lhs0   = CMPW'(s5_c0sq_q) << (2 * DIST_FRAC);
  assign lhs1   = CMPW'(s5_c1sq_q) << (2 * DIST_FRAC);

  always_comb begin
    if (s5_lu0_q)                         cls0 = CLS_LEFT;
    else if (s5_pos0_q && lhs0 > rr_sum)  cls0 = CLS_RIGHT;
    else if (lhs0 < ri_sum)               cls0 = CLS_ON;
    else                                  cls0 = CLS_LEFT;
    if (s5_lu0_q)                         cls1 = CLS_LEFT;
    else if (s5_pos1_q && lhs1 > rr_sum)  cls1 = CLS_RIGHT;
    else if (lhs1 < ri_sum)               cls1 = CLS_ON;
    else                                  cls1 = CLS_LEFT;
  end

  assign straddle_d = (cls0 != CLS_ON) && (cls1 != CLS_ON) && (cls0 != cls1);
  assign lulv_ext   = (3 * CK)'(s5_lulv_q);
  assign rph[0]     = rp2_q[EH-1:0];
  assign rph[1]     = rp2_q[E2W-1:EH];

  always_comb begin
    for (int j = 0; j < 3; j++) chunk[j] = lulv_ext[j*CK +: CK];
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 3; j++) pp_d[i][j] = rph[i] * chunk[j];
    end
  end

  // Stage 7: sum of the parallel bound.
  logic [CMPW-1:0] psum_d;
  logic [CMPW-1:0] s7_psum_q;
  logic            s7_straddle_q, s7_ok_q, s7_lu0_q, s7_lv0_q;
  logic [2*MW-1:0] s7_dsq_q;
  logic [NW-1:0]   s7_nx_q, s7_ny_q;
  logic [MW-1:0]   s7_dn_q;
  logic            s7_negx_q, s7_negy_q;
  logic signed [COORD_BITS-1:0] s7_ax_q, s7_ay_q;

  always_comb begin
    psum_d = '0;
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 3; j++) begin
        psum_d = psum_d + (CMPW'(s6_pp_q[i][j]) << (EH * i + CK * j));
      end
    end
  end

  // Stage 8: parallel test and the found decision.
  logic [CMPW-1:0] lhsp;
  logic            par_d, found_d;
  sit_div_in_t     s8_d, s8_q;

  assign lhsp    = CMPW'(s7_dsq_q) << (2 * DIST_FRAC);
  assign par_d   = !s7_lu0_q && !s7_lv0_q && (lhsp <= s7_psum_q);
  assign found_d = !s7_lu0_q && !s7_lv0_q && !par_d && inz_q && s7_ok_q;

  always_comb begin
    s8_d.side.strict_hit = s7_straddle_q && found_d;
    s8_d.side.found      = found_d;
    s8_d.side.parallel   = par_d;
    s8_d.side.neg_x      = s7_negx_q;
    s8_d.side.neg_y      = s7_negy_q;
    s8_d.side.ax         = s7_ax_q;
    s8_d.side.ay         = s7_ay_q;
    s8_d.den             = s7_dn_q;
    s8_d.nx              = s7_nx_q;
    s8_d.ny              = s7_ny_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_ux_q <= ux_d; s1_uy_q <= uy_d; s1_vx_q <= vx_d; s1_vy_q <= vy_d;
      s1_wx_q <= wx_d; s1_wy_q <= wy_d; s1_ex_q <= ex_d; s1_ey_q <= ey_d;
      s1_ax_q <= a_start_x_i; s1_ay_q <= a_start_y_i;

      s2_uxwy_q <= p_uxwy_d; s2_uywx_q <= p_uywx_d;
      s2_uxey_q <= p_uxey_d; s2_uyex_q <= p_uyex_d;
      s2_uxvy_q <= p_uxvy_d; s2_uyvx_q <= p_uyvx_d;
      s2_wxvy_q <= p_wxvy_d; s2_wyvx_q <= p_wyvx_d;
      s2_qux_q  <= q_ux_d;   s2_quy_q  <= q_uy_d;
      s2_qvx_q  <= q_vx_d;   s2_qvy_q  <= q_vy_d;
      s2_abx_q  <= abx_d[COORD_BITS-1:0];
      s2_aby_q  <= aby_d[COORD_BITS-1:0];
      s2_negx_q <= s1_ux_q[DW-1];
      s2_negy_q <= s1_uy_q[DW-1];
      s2_ax_q   <= s1_ax_q; s2_ay_q <= s1_ay_q;

      s3_cr0_q <= cr0_d; s3_cr1_q <= cr1_d; s3_den_q <= den_d; s3_tn_q <= tn_d;
      s3_lu_q  <= lu_d;  s3_lv_q  <= lv_d;
      s3_abx_q <= s2_abx_q; s3_aby_q <= s2_aby_q;
      s3_negx_q <= s2_negx_q; s3_negy_q <= s2_negy_q;
      s3_ax_q  <= s2_ax_q; s3_ay_q <= s2_ay_q;

      s4_dn_q   <= dn_d; s4_tnn_q <= tnn_d; s4_snn_q <= snn_d;
      s4_m0_q   <= m0_full[MW-1:0];
      s4_m1_q   <= m1_full[MW-1:0];
      s4_pos0_q <= !s3_cr0_q[PW-1] && (s3_cr0_q != '0);
      s4_pos1_q <= !s3_cr1_q[PW-1] && (s3_cr1_q != '0);
      s4_lu0_q  <= (s3_lu_q == '0);
      s4_lv0_q  <= (s3_lv_q == '0);
      s4_lu_q   <= s3_lu_q; s4_lv_q <= s3_lv_q;
      s4_abx_q  <= s3_abx_q; s4_aby_q <= s3_aby_q;
      s4_negx_q <= s3_negx_q; s4_negy_q <= s3_negy_q;
      s4_ax_q   <= s3_ax_q; s4_ay_q <= s3_ay_q;

      s5_ok_q   <= ok_d;
      s5_pos0_q <= s4_pos0_q; s5_pos1_q <= s4_pos1_q;
      s5_lu0_q  <= s4_lu0_q;  s5_lv0_q  <= s4_lv0_q;
      s5_c0sq_q <= c0sq_d; s5_c1sq_q <= c1sq_d; s5_dsq_q <= dsq_d;
      s5_rrh_q  <= rrh_d; s5_rrl_q <= rrl_d; s5_rih_q <= rih_d; s5_ril_q <= ril_d;
      s5_lulv_q <= lulv_d;
      s5_nx_q   <= nx_d; s5_ny_q <= ny_d;
      s5_dn_q   <= s4_dn_q[MW-1:0];
      s5_negx_q <= s4_negx_q; s5_negy_q <= s4_negy_q;
      s5_ax_q   <= s4_ax_q; s5_ay_q <= s4_ay_q;

      for (int i = 0; i < 2; i++) begin
        for (int j = 0; j < 3; j++) s6_pp_q[i][j] <= pp_d[i][j];
      end
      s6_straddle_q <= straddle_d;
      s6_ok_q   <= s5_ok_q;
      s6_lu0_q  <= s5_lu0_q; s6_lv0_q <= s5_lv0_q;
      s6_dsq_q  <= s5_dsq_q;
      s6_nx_q   <= s5_nx_q; s6_ny_q <= s5_ny_q;
      s6_dn_q   <= s5_dn_q;
      s6_negx_q <= s5_negx_q; s6_negy_q <= s5_negy_q;
      s6_ax_q   <= s5_ax_q; s6_ay_q <= s5_ay_q;

      s7_psum_q     <= psum_d;
      s7_straddle_q <= s6_straddle_q;
      s7_ok_q   <= s6_ok_q;
      s7_lu0_q  <= s6_lu0_q; s7_lv0_q <= s6_lv0_q;
      s7_dsq_q  <= s6_dsq_q;
      s7_nx_q   <= s6_nx_q; s7_ny_q <= s6_ny_q;
      s7_dn_q   <= s6_dn_q;
      s7_negx_q <= s6_negx_q; s7_negy_q <= s6_negy_q;
      s7_ax_q   <= s6_ax_q; s7_ay_q <= s6_ay_q;

      s8_q <= s8_d;
    end
  end

  logic         dv;
  sit_div_out_t dout;

  sit_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (adv),
    .in_valid_i  (v8_q),
    .in_i        (s8_q),
    .out_valid_o (dv),
    .out_o       (dout)
  );

  // Round half away from zero on the magnitude, then move from the segment start.
  logic [QW:0]  qxr, qyr;
  logic [VW-1:0] basex, basey, vx_res, vy_res;
  sit_res_t     res_d;

  assign qxr   = {1'b0, dout.qx} + (QW+1)'({dout.rx, 1'b0} >= {1'b0, dout.den});
  assign qyr   = {1'b0, dout.qy} + (QW+1)'({dout.ry, 1'b0} >= {1'b0, dout.den});
  assign basex = VW'(dout.side.ax) << FRAC_BITS;
  assign basey = VW'(dout.side.ay) << FRAC_BITS;
  assign vx_res = dout.side.neg_x ? basex - VW'(qxr) : basex + VW'(qxr);
  assign vy_res = dout.side.neg_y ? basey - VW'(qyr) : basey + VW'(qyr);

  always_comb begin
    res_d.strict_hit = dout.side.strict_hit;
    res_d.found      = dout.side.found;
    res_d.parallel   = dout.side.parallel;
    res_d.cx         = dout.side.found ? vx_res[OUT_W-1:0] : '0;
    res_d.cy         = dout.side.found ? vy_res[OUT_W-1:0] : '0;
  end

  // Two-entry output buffer.
  sit_res_t buf_q [2];
  logic     wp_q, rp_q;
  logic     push, pop;

  assign push = adv && dv;
  assign pop  = out_valid_o && out_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop)      cnt_d = cnt_q + 2'd1;
    else if (pop && !push) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wp_q <= !wp_q;
      if (pop)  rp_q <= !rp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wp_q] <= res_d;
  end

  assign out_valid_o      = (cnt_q != 2'd0);
  assign strict_hit_o     = buf_q[rp_q].strict_hit;
  assign point_found_o    = buf_q[rp_q].found;
  assign lines_parallel_o = buf_q[rp_q].parallel;
  assign cross_x_o        = buf_q[rp_q].cx;
  assign cross_y_o        = buf_q[rp_q].cy;

endmodule

FILE: rtl/core/sit_div.sv
// Pipelined restoring divider, one quotient bit per stage, two lanes sharing one divisor.
module sit_div import sit_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         in_valid_i,
  input  sit_div_in_t  in_i,
  output logic         out_valid_o,
  output sit_div_out_t out_o
);

  typedef struct packed {
    logic [MW-1:0] rem;
    logic [QW-1:0] lo;
    logic [QW-1:0] quo;
  } lane_t;

  typedef struct packed {
    sit_side_t     side;
    logic [MW-1:0] den;
    lane_t         x;
    lane_t         y;
  } stage_t;

  function automatic lane_t lane_prep(input logic [NW-1:0] n);
    logic [NW+FRAC_BITS-1:0] dvd;
    lane_t                   l;
    dvd   = {n, {FRAC_BITS{1'b0}}};
    l.rem = dvd[NW+FRAC_BITS-1:QW];
    l.lo  = dvd[QW-1:0];
    l.quo = '0;
    return l;
  endfunction

  function automatic lane_t lane_step(input lane_t l, input logic [MW-1:0] den);
    logic [MW:0] t;
    logic [MW:0] diff;
    logic        ge;
    lane_t       r;
    t     = {l.rem, l.lo[QW-1]};
    diff  = t - {1'b0, den};
    ge    = (t >= {1'b0, den});
    r.rem = ge ? diff[MW-1:0] : t[MW-1:0];
    r.lo  = {l.lo[QW-2:0], 1'b0};
    r.quo = {l.quo[QW-2:0], ge};
    return r;
  endfunction

  stage_t st_q [QW];
  stage_t st_d [QW];
  logic   vld_q [QW];

  always_comb begin
    st_d[0].side = in_i.side;
    st_d[0].den  = in_i.den;
    st_d[0].x    = lane_step(lane_prep(in_i.nx), in_i.den);
    st_d[0].y    = lane_step(lane_prep(in_i.ny), in_i.den);
    for (int k = 1; k < QW; k++) begin
      st_d[k].side = st_q[k-1].side;
      st_d[k].den  = st_q[k-1].den;
      st_d[k].x    = lane_step(st_q[k-1].x, st_q[k-1].den);
      st_d[k].y    = lane_step(st_q[k-1].y, st_q[k-1].den);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < QW; k++) vld_q[k] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= in_valid_i;
      for (int k = 1; k < QW; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < QW; k++) st_q[k] <= st_d[k];
    end
  end

  assign out_valid_o = vld_q[QW-1];
  assign out_o.side  = st_q[QW-1].side;
  assign out_o.den   = st_q[QW-1].den;
  assign out_o.qx    = st_q[QW-1].x.quo;
  assign out_o.rx    = st_q[QW-1].x.rem;
  assign out_o.qy    = st_q[QW-1].y.quo;
  assign out_o.ry    = st_q[QW-1].y.rem;

endmodule

FILE: rtl/core/sit_chk.sv
// Port-level assertions for the segment intersection test core, bound to the top level.
module sit_chk import sit_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_ready_o,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic                    strict_hit_o,
  input logic                    point_found_o,
  input logic                    lines_parallel_o,
  input logic signed [OUT_W-1:0] cross_x_o,
  input logic signed [OUT_W-1:0] cross_y_o
);

  // A strict hit needs a found crossing.
  a_hit_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && strict_hit_o |-> point_found_o)
    else $error("strict hit without a found crossing");

  // A crossing is never found on parallel lines.
  a_found_not_par: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && point_found_o |-> !lines_parallel_o)
    else $error("crossing found on parallel lines");

  // Without a crossing the coordinates read zero.
  a_zero_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !point_found_o |-> (cross_x_o == '0) && (cross_y_o == '0))
    else $error("nonzero crossing without a found point");

  // A stalled result holds until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(cross_x_o) &&
    $stable(cross_y_o) && $stable(point_found_o))
    else $error("stalled result changed");

  // The input side only holds while results are waiting.
  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input held with no result waiting");

endmodule

bind segment_intersection_test_core sit_chk u_sit_chk (.*);

FILE: verif/tb_top.sv
// Self-checking testbench for the segment intersection test core.
module tb_top;
  import sit_pkg::*;

  localparam int GAP_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic signed [COORD_BITS-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
  } seg_pair_t;

  typedef struct {
    logic                    hit;
    logic                    found;
    logic                    par;
    logic signed [OUT_W-1:0] cx;
    logic signed [OUT_W-1:0] cy;
  } crossing_t;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [EPS_W-1:0] cfg_wdata_i;
  logic in_valid_i, in_ready_o;
  logic signed [COORD_BITS-1:0] a_start_x_i, a_start_y_i, a_end_x_i, a_end_y_i;
  logic signed [COORD_BITS-1:0] b_start_x_i, b_start_y_i, b_end_x_i, b_end_y_i;
  logic out_valid_o, out_ready_i;
  logic strict_hit_o, point_found_o, lines_parallel_o;
  logic signed [OUT_W-1:0] cross_x_o, cross_y_o;

  segment_intersection_test_core u_top (.*);

  crossing_t pending_q[$];
  int errors = 0;
  int idle_cycles = 0;
  int pairs_sent = 0;
  int crossings_seen = 0;
  int hits_seen = 0;
  bit sink_busy = 1'b0;

  logic [EPS_W-1:0] inter_eps, right_eps, parallel_eps;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Random gap length: mostly short, sometimes long, often none.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [255:0] umag(logic signed [127:0] v);
    return (v < 0) ? -v : v;
  endfunction

  // Side of a point relative to line A, compared squared and exactly.
  function automatic sit_cls_e classify(logic signed [127:0] cr, logic [255:0] len);
    logic [255:0] lhs, rhs;
    if (len == 0) return CLS_LEFT;
    lhs = (umag(cr) * umag(cr)) << (2 * DIST_FRAC);
    rhs = 256'(right_eps) * right_eps * len;
    if (cr > 0 && lhs > rhs) return CLS_RIGHT;
    rhs = 256'(inter_eps) * inter_eps * len;
    if (lhs < rhs) return CLS_ON;
    return CLS_LEFT;
  endfunction

  // origin + d*num/den in fixed point, rounded half away from zero.
  function automatic logic signed [OUT_W-1:0] fix_point(logic signed [127:0] org,
      logic signed [127:0] d, logic signed [127:0] num, logic signed [127:0] den);
    logic [255:0] q;
    logic signed [127:0] v;
    q = ((umag(d) * num) * (256'(1) << (FRAC_BITS + 1)) + den) / (2 * den);
    v = org <<< FRAC_BITS;
    v = (d < 0) ? v - $signed(q[127:0]) : v + $signed(q[127:0]);
    return v[OUT_W-1:0];
  endfunction

  function automatic crossing_t predict_crossing(seg_pair_t p);
    crossing_t r;
    logic signed [127:0] ux, uy, vx, vy, wx, wy, den, tn, sn;
    logic [255:0] lu, lv, lhs, rhs;
    sit_cls_e c0, c1;
    logic straddle;
    ux = p.ax1 - p.ax0; uy = p.ay1 - p.ay0;
    vx = p.bx1 - p.bx0; vy = p.by1 - p.by0;
    wx = p.bx0 - p.ax0; wy = p.by0 - p.ay0;
    lu = ux * ux + uy * uy;
    lv = vx * vx + vy * vy;
    c0 = classify(ux * wy - uy * wx, lu);
    c1 = classify(ux * (wy + vy) - uy * (wx + vx), lu);
    straddle = c0 != CLS_ON && c1 != CLS_ON && c0 != c1;
    den = ux * vy - uy * vx;
    tn = wx * vy - wy * vx;
    sn = wx * uy - wy * ux;
    r = '{default: '0};
    if (lu != 0 && lv != 0) begin
      lhs = (umag(den) * umag(den)) << (2 * DIST_FRAC);
      rhs = 256'(parallel_eps) * parallel_eps * lu * lv;
      r.par = lhs <= rhs;
      if (!r.par) begin
        if (den < 0) begin
          den = -den; tn = -tn; sn = -sn;
        end
        r.found = inter_eps != 0 && tn > 0 && tn < den && sn > 0 && sn < den;
      end
    end
    if (r.found) begin
      r.cx = fix_point(p.ax0, ux, tn, den);
      r.cy = fix_point(p.ay0, uy, tn, den);
    end
    r.hit = straddle && r.found;
    return r;
  endfunction

  task automatic write_threshold(sit_cfg_e idx, logic [EPS_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_INTER_EPS:    inter_eps = val;
      CFG_RIGHT_EPS:    right_eps = val;
      CFG_PARALLEL_EPS: parallel_eps = val;
      default: ;
    endcase
  endtask

  task automatic set_thresholds(logic [EPS_W-1:0] ie, logic [EPS_W-1:0] re,
      logic [EPS_W-1:0] pe);
    write_threshold(CFG_INTER_EPS, ie);
    write_threshold(CFG_RIGHT_EPS, re);
    write_threshold(CFG_PARALLEL_EPS, pe);
    cfg_we_i <= 1'b0;
  endtask

  // Sends one request and queues its expected result when it is accepted.
  task automatic send_pair(seg_pair_t p);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    a_start_x_i <= p.ax0; a_start_y_i <= p.ay0; a_end_x_i <= p.ax1; a_end_y_i <= p.ay1;
    b_start_x_i <= p.bx0; b_start_y_i <= p.by0; b_end_x_i <= p.bx1; b_end_y_i <= p.by1;
    do @(posedge clk_i); while (!in_ready_o);
    pending_q.push_back(predict_crossing(p));
    pairs_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic signed [COORD_BITS-1:0] rnd_coord(int span);
    if (span == 0) return $signed(COORD_BITS'($urandom));
    return $signed(COORD_BITS'($urandom_range(0, 2 * span) - span));
  endfunction

  function automatic seg_pair_t rnd_pair(int span);
    seg_pair_t p;
    p.ax0 = rnd_coord(span); p.ay0 = rnd_coord(span);
    p.ax1 = rnd_coord(span); p.ay1 = rnd_coord(span);
    p.bx0 = rnd_coord(span); p.by0 = rnd_coord(span);
    p.bx1 = rnd_coord(span); p.by1 = rnd_coord(span);
    return p;
  endfunction

  // Builds B through the midpoint of A so that most pairs really cross.
  function automatic seg_pair_t crossing_pair(int span);
    seg_pair_t p;
    int mx, my, dx, dy;
    p.ax0 = rnd_coord(span); p.ay0 = rnd_coord(span);
    p.ax1 = rnd_coord(span); p.ay1 = rnd_coord(span);
    mx = (int'(p.ax0) + int'(p.ax1)) / 2;
    my = (int'(p.ay0) + int'(p.ay1)) / 2;
    dx = $urandom_range(0, 2 * span) - span;
    dy = $urandom_range(0, 2 * span) - span;
    p.bx0 = COORD_BITS'(mx - dx); p.by0 = COORD_BITS'(my - dy);
    p.bx1 = COORD_BITS'(mx + dx); p.by1 = COORD_BITS'(my + dy);
    return p;
  endfunction

  task automatic test_directed();
    localparam logic signed [COORD_BITS-1:0] MX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] MN = {1'b1, {(COORD_BITS-1){1'b0}}};
    // Plain crossing, X shape.
    send_pair('{-10, 0, 10, 0, 0, -10, 0, 10});
    send_pair('{0, 0, 7, 3, 2, 5, 5, -4});
    // Touching at an endpoint of B and at an endpoint of A.
    send_pair('{-10, 0, 10, 0, 0, 0, 0, 10});
    send_pair('{-10, 0, 10, 0, -10, -5, -10, 5});
    // Parallel and collinear.
    send_pair('{0, 0, 10, 0, 0, 5, 10, 5});
    send_pair('{0, 0, 10, 0, 2, 0, 8, 0});
    // Degenerate segments.
    send_pair('{3, 3, 3, 3, 0, 0, 5, 5});
    send_pair('{-5, 0, 5, 0, 1, 1, 1, 1});
    // Crossing outside one segment.
    send_pair('{0, 0, 10, 0, 20, -5, 20, 5});
    // Coordinate extremes.
    send_pair('{MN, MN, MX, MX, MN, MX, MX, MN});
    send_pair('{MX, MN, MN, MX, MN, MN, MX, MX});
    send_pair('{MN, 0, MX, 0, 0, MN, 1, MX});
    send_pair('{MN, MN, MX, MN, MN, MX, MX, MN});
    send_pair('{-1, -1, 0, 0, -1, 0, 0, -1});
    wait_drained();
  endtask

  task automatic test_threshold_extremes();
    // No on-line band: nothing can be found.
    set_thresholds(0, 0, 0);
    send_pair('{-10, 0, 10, 0, 0, -10, 0, 10});
    send_pair('{0, 0, 10, 0, 0, 5, 10, 5});
    wait_drained();
    // Everything parallel; right below inter, the odd band.
    set_thresholds(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_pair('{-10, 0, 10, 0, 0, -10, 0, 10});
    wait_drained();
    set_thresholds(1000, 10, 1);
    send_pair('{-10, 0, 10, 0, 0, -10, 0, 10});
    send_pair('{-100, 0, 100, 0, 3, -7, 5, 9});
    wait_drained();
  endtask

  task automatic test_random(int count);
    int r, span;
    for (int i = 0; i < count; i++) begin
      if (i % 150 == 0) begin
        wait_drained();
        case ((i / 150) % 4)
          0: set_thresholds(2, 200, 2);
          1: set_thresholds($urandom_range(1, 50), $urandom_range(0, 5000),
                            $urandom_range(0, 1 << 20));
          2: set_thresholds(EPS_W'($urandom), EPS_W'($urandom), EPS_W'($urandom));
          default: set_thresholds(1, 0, 0);
        endcase
      end
      r = $urandom_range(0, 99);
      span = (r % 3 == 0) ? 0 : (r % 3 == 1) ? 100 : 20000;
      if (r < 75) send_pair(crossing_pair(span == 0 ? 16000 : span));
      else send_pair(rnd_pair(span));
    end
    wait_drained();
  endtask

  // Result side: random stalls and comparison against the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    crossing_t e;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (pending_q.size() == 0) begin
          $error("result without pending request");
          errors++;
        end else begin
          e = pending_q.pop_front();
          crossings_seen += point_found_o;
          hits_seen += strict_hit_o;
          if (strict_hit_o !== e.hit) begin
            $error("strict_hit expected %0b got %0b", e.hit, strict_hit_o); errors++;
          end
          if (point_found_o !== e.found) begin
            $error("point_found expected %0b got %0b", e.found, point_found_o); errors++;
          end
          if (lines_parallel_o !== e.par) begin
            $error("lines_parallel expected %0b got %0b", e.par, lines_parallel_o);
            errors++;
          end
          if (cross_x_o !== e.cx) begin
            $error("cross_x expected %0d got %0d", e.cx, cross_x_o); errors++;
          end
          if (cross_y_o !== e.cy) begin
            $error("cross_y expected %0d got %0d", e.cy, cross_y_o); errors++;
          end
        end
      end
      if (sink_busy) out_ready_i <= ($urandom_range(0, 9) != 0);
      else out_ready_i <= 1'b1;
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= GAP_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    {a_start_x_i, a_start_y_i, a_end_x_i, a_end_y_i} = '0;
    {b_start_x_i, b_start_y_i, b_end_x_i, b_end_y_i} = '0;
    inter_eps = INTER_EPS_RST;
    right_eps = RIGHT_EPS_RST;
    parallel_eps = PARALLEL_EPS_RST;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    sink_busy = 1'b1;
    test_threshold_extremes();
    test_random(600);
    $display("Sent %0d segment pairs over several threshold settings.", pairs_sent);
    $display("Crossings found: %0d, strict hits: %0d.", crossings_seen, hits_seen);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
